### sv/terminal_key_sequence_decoder_macros.svh
// ----------------------------------------------------------------------------
// terminal key sequence decoder assertion macros
// shared assertion forms for the checker of the decoder ports
// ----------------------------------------------------------------------------
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_MACROS_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_MACROS_SVH

// property checked only while out of reset
`define TKSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tksd port check failed");

// property checked on every edge, reset included
`define TKSD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tksd port check failed at every edge");

`endif

### sv/tksd_pkg.sv
// ----------------------------------------------------------------------------
// tksd_pkg
// types, byte codes and key lookups of the terminal key sequence decoder
// ----------------------------------------------------------------------------
package tksd_pkg;

  // byte codes
  localparam logic [7:0] CH_ESC      = 8'd27;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_ONE      = 8'h31;
  localparam logic [7:0] CH_TWO      = 8'h32;
  localparam logic [7:0] CH_EIGHT    = 8'h38;

  // byte position codes
  localparam logic [2:0] POS_ESC     = 3'd0;
  localparam logic [2:0] POS_BRACKET = 3'd1;
  localparam logic [2:0] POS_PARAM   = 3'd2;
  localparam logic [2:0] POS_SEP     = 3'd3;
  localparam logic [2:0] POS_MOD     = 3'd4;
  localparam logic [2:0] POS_FINAL   = 3'd5;
  localparam logic [2:0] POS_MAX     = 3'd7;

  // key and parameter codes
  localparam logic [3:0] KEY_UP       = 4'd0;
  localparam logic [3:0] KEY_DOWN     = 4'd1;
  localparam logic [3:0] KEY_RIGHT    = 4'd2;
  localparam logic [3:0] KEY_LEFT     = 4'd3;
  localparam logic [3:0] KEY_HOME     = 4'd4;
  localparam logic [3:0] KEY_END      = 4'd5;
  localparam logic [3:0] KEY_INSERT   = 4'd6;
  localparam logic [3:0] KEY_DELETE   = 4'd7;
  localparam logic [3:0] KEY_PAGEUP   = 4'd8;
  localparam logic [3:0] KEY_PAGEDOWN = 4'd9;
  localparam logic [3:0] PARAM_ONE    = 4'd10;
  localparam logic [3:0] NO_KEY       = 4'd15;

  // one decoded result
  typedef struct packed {
    logic       found;
    logic [3:0] key_number;
    logic [2:0] modifier_bits;
  } tksd_result_t;

  // final letter of a cursor key form
  function automatic logic [3:0] cursor_key(input logic [7:0] b);
    logic [3:0] k;
    case (b)
      8'h41:   k = KEY_UP;
      8'h42:   k = KEY_DOWN;
      8'h43:   k = KEY_RIGHT;
      8'h44:   k = KEY_LEFT;
      8'h48:   k = KEY_HOME;
      8'h46:   k = KEY_END;
      default: k = NO_KEY;
    endcase
    return k;
  endfunction

  // numeric parameter of a tilde key form
  function automatic logic [3:0] tilde_key(input logic [7:0] b);
    logic [3:0] k;
    case (b)
      8'h32:   k = KEY_INSERT;
      8'h33:   k = KEY_DELETE;
      8'h35:   k = KEY_PAGEUP;
      8'h36:   k = KEY_PAGEDOWN;
      default: k = NO_KEY;
    endcase
    return k;
  endfunction

  function automatic logic is_tilde_param(input logic [3:0] p);
    return (p >= KEY_INSERT) && (p <= KEY_PAGEDOWN);
  endfunction

endpackage

### sv/tksd_parse.sv
// ----------------------------------------------------------------------------
// tksd_parse
// per-byte match logic and sequence state; gives the result on the last byte
// ----------------------------------------------------------------------------
module tksd_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_valid,
  input  logic [7:0]            step_byte,
  input  logic                  step_last,
  output tksd_pkg::tksd_result_t result
);
  import tksd_pkg::*;

  logic [2:0] pos_r, pos_nxt;
  logic       match_r, match_nxt;
  logic [3:0] fparam_r, fparam_nxt;
  logic [2:0] mod_r, mod_nxt;

  logic       match;
  logic       hit;
  logic [3:0] key;
  logic [2:0] mod;
  logic [3:0] ck;
  logic [3:0] tk;
  logic [7:0] mod_diff;

  assign ck       = cursor_key(step_byte);
  assign tk       = tilde_key(step_byte);
  assign mod_diff = step_byte - CH_ONE;

  // match step for the current byte position
  always_comb begin
    match      = match_r;
    hit        = 1'b0;
    key        = '0;
    mod        = '0;
    fparam_nxt = fparam_r;
    mod_nxt    = mod_r;
    unique case (pos_r)
      POS_ESC: begin
        if (step_byte != CH_ESC) match = 1'b0;
      end
      POS_BRACKET: begin
        if (step_byte != CH_LBRACKET) match = 1'b0;
      end
      POS_PARAM: begin
        if (ck != NO_KEY) begin
          if (step_last) begin
            hit = 1'b1;
            key = ck;
          end else begin
            match = 1'b0;
          end
        end else if (step_byte == CH_ONE) begin
          fparam_nxt = PARAM_ONE;
        end else if (tk != NO_KEY) begin
          fparam_nxt = tk;
        end else begin
          match = 1'b0;
        end
      end
      POS_SEP: begin
        if (fparam_r == PARAM_ONE) begin
          if (step_byte != CH_SEMI) match = 1'b0;
        end else if (is_tilde_param(fparam_r)) begin
          if (step_byte == CH_SEMI) begin
            // modified tilde form continues
          end else if (step_byte == CH_TILDE && step_last) begin
            hit = 1'b1;
            key = fparam_r;
          end else begin
            match = 1'b0;
          end
        end else begin
          match = 1'b0;
        end
      end
      POS_MOD: begin
        if (step_byte >= CH_TWO && step_byte <= CH_EIGHT) mod_nxt = mod_diff[2:0];
        else match = 1'b0;
      end
      POS_FINAL: begin
        if (fparam_r == PARAM_ONE) begin
          if (ck != NO_KEY && step_last) begin
            hit = 1'b1;
            key = ck;
            mod = mod_r;
          end else begin
            match = 1'b0;
          end
        end else if (is_tilde_param(fparam_r) && step_byte == CH_TILDE && step_last) begin
          hit = 1'b1;
          key = fparam_r;
          mod = mod_r;
        end else begin
          match = 1'b0;
        end
      end
      default: begin
        match = 1'b0;
      end
    endcase
  end

  // result fields, zero unless the whole sequence matched
  always_comb begin
    result.found         = match_r && hit;
    result.key_number    = (match_r && hit) ? key : '0;
    result.modifier_bits = (match_r && hit) ? mod : '0;
  end

  // next sequence state
  always_comb begin
    pos_nxt   = pos_r;
    match_nxt = match_r;
    if (step_valid) begin
      if (step_last) begin
        pos_nxt   = POS_ESC;
        match_nxt = 1'b1;
      end else begin
        if (pos_r != POS_MAX) pos_nxt = pos_r + 3'd1;
        match_nxt = match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_ESC;
      match_r  <= 1'b1;
      fparam_r <= '0;
      mod_r    <= '0;
    end else begin
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
      if (step_valid) begin
        if (step_last) begin
          fparam_r <= '0;
          mod_r    <= '0;
        end else begin
          fparam_r <= fparam_nxt;
          mod_r    <= mod_nxt;
        end
      end
    end
  end

endmodule

### sv/tksd_out_reg.sv
// ----------------------------------------------------------------------------
// tksd_out_reg
// result register holding one item until the downstream side takes it
// ----------------------------------------------------------------------------
module tksd_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  tksd_pkg::tksd_result_t load_data,
  output logic                   can_load,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tuser
);
  import tksd_pkg::*;

  logic         valid_r, valid_nxt;
  tksd_result_t data_r;

  assign can_load = !valid_r || out_tready;

  // valid flag: set on load, cleared once the item leaves
  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= load_data;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, data_r.modifier_bits, data_r.key_number};
  assign out_tuser  = data_r.found;

endmodule

### sv/terminal_key_sequence_decoder.sv
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder
// decodes cursor and editing key escape sequences, one byte per item
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | slave     | in_tvalid in_tready in_tdata in_tlast
//  out     | master    | out_tvalid out_tready out_tdata out_tuser
//
//  one byte per cycle unless a held result stalls; a byte waits in the input
//  register; a last-marked byte's result then sits in the result register
//  synchronous active-low reset returns the sequence state to its start
//  a held result stalls only last-marked bytes; other bytes keep flowing
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] seq_byte
  input  logic       in_tlast,   // seq_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] key_number, [6:4] modifier_bits, [7] zero
  output logic       out_tuser   // found
);
  import tksd_pkg::*;

  logic         in_v_r, in_v_nxt;
  logic [7:0]   in_byte_r;
  logic         in_last_r;
  logic         can_load;
  logic         adv;
  tksd_result_t result;

  // input register advances unless its last byte would hit a full output
  assign adv       = in_v_r && (!in_last_r || can_load);
  assign in_tready = !in_v_r || adv;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) in_v_nxt = 1'b1;
    else if (adv) in_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // sequence matching
  tksd_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (adv),
    .step_byte  (in_byte_r),
    .step_last  (in_last_r),
    .result     (result)
  );

  // result register
  tksd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv && in_last_r),
    .load_data  (result),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### sv/tksd_checker.sv
// ----------------------------------------------------------------------------
// tksd_checker
// port-level checks of the terminal key sequence decoder, bound to the top
// ----------------------------------------------------------------------------
`include "terminal_key_sequence_decoder_macros.svh"

module tksd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser
);

  // no result straight out of reset
  `TKSD_ASSERT(a_idle_after_reset, !$past(rst_n) |-> !out_tvalid)

  // a miss carries zero key and modifier
  `TKSD_ASSERT(a_miss_zero, (out_tvalid && !out_tuser) |-> (out_tdata == 8'd0))

  // a hit names a known key and keeps the pad bit clear
  `TKSD_ASSERT(a_hit_key_range, (out_tvalid && out_tuser) |-> ((out_tdata[3:0] <= 4'd9) && !out_tdata[7]))

  // input never stalls while the output can take an item
  `TKSD_ASSERT(a_ready_when_free, (!out_tvalid || out_tready) |-> in_tready)

  // a stalled result holds
  `TKSD_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (.*);
